/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Depends on nothing; a file includes it before its first assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pawo_pkg.sv */
// Package of the phase accumulator oscillator: field widths, register indexes,
// waveform codes and fixed constants. Depends on nothing.
package pawo_pkg;

   localparam int FREQ_W     = 24;
   localparam int TICK_W     = 32;
   localparam int PHASE_W    = 32;
   localparam int WAVE_W     = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int PROD_W     = FREQ_W + TICK_W + 1;
   localparam int STEP_LSB   = 16;

   localparam logic [TICK_W-1:0]  TICK_PERIOD_RESET = 32'd22906492;
   localparam logic [PHASE_W-1:0] HALF_CYCLE        = 32'h8000_0000;

   // pi/2 in Q30, used only while the sine table is built at elaboration.
   localparam longint PI2_Q30 = 64'sd1686629713;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WAVE_SELECT = 2'd0,
      CSR_TICK_PERIOD = 2'd1
   } csr_index_type;

   typedef enum logic [WAVE_W-1:0] {
      WAVE_SINE     = 3'd0,
      WAVE_SQUARE   = 3'd1,
      WAVE_SAW      = 3'd2,
      WAVE_TRIANGLE = 3'd3
   } wave_type;

endpackage

/* rtl/pawo_ifs.sv */
// Channel interfaces of the phase accumulator oscillator: input items,
// result items and register writes. Depends on pawo_pkg.
interface pawo_req_if;
   import pawo_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [FREQ_W-1:0] frequency;
   modport source (output valid, output frequency, input ready);
   modport sink   (input valid, input frequency, output ready);
endinterface

interface pawo_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   import pawo_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic [PHASE_W-1:0]            phase_now;
   modport source (output valid, output sample, output phase_now, input ready);
   modport sink   (input valid, input sample, input phase_now, output ready);
endinterface

interface pawo_csr_if;
   import pawo_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/pawo_phase_store.sv */
// One-entry phase memory with a registered read and write forwarding.
// Depends on pawo_pkg.
module pawo_phase_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [pawo_pkg::PHASE_W-1:0]  wr_data,
   output logic [pawo_pkg::PHASE_W-1:0]  rd_data
);
   import pawo_pkg::*;

   logic [PHASE_W-1:0] mem [0:0];
   logic [PHASE_W-1:0] rd_ff;
   logic [PHASE_W-1:0] fwd_data_ff;
   logic               fwd_ff;
   logic               written_ff;
   logic               rd_written_ff;

   // The read is issued every cycle; a write in the previous cycle is newer than
   // the read data and is forwarded. An entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[0] <= wr_data;
      end
      rd_ff       <= mem[0];
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff        <= 1'b0;
         written_ff    <= 1'b0;
         rd_written_ff <= 1'b0;
      end else begin
         fwd_ff        <= wr_en;
         written_ff    <= written_ff | wr_en;
         rd_written_ff <= written_ff;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (rd_written_ff) begin
         rd_data = rd_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

/* rtl/pawo_sine_rom.sv */
// Quarter-wave sine table, built at elaboration, with a registered read.
// Depends on pawo_pkg.
module pawo_sine_rom #(
   parameter int DEPTH = 1024,
   parameter int SB    = 16,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] addr,
   output logic [SB-2:0] rd_data
);
   import pawo_pkg::*;

   localparam longint SCALE = longint'(1) << (SB - 1);
   localparam longint SMAX  = SCALE - 1;

   typedef logic [SB-2:0] rom_type [0:DEPTH];

   // Quotient of two non-negative elaboration constants by long division.
   function automatic longint const_quotient(input longint num, input longint den);
      longint q;
      longint r;
      q = 0;
      r = 0;
      for (int i = 62; i >= 0; i--) begin
         r = (r << 1) | ((num >> i) & longint'(1));
         if (r >= den) begin
            r = r - den;
            q = q | (longint'(1) << i);
         end
      end
      return q;
   endfunction

   // Entry k is sin(pi/2 * k / DEPTH) from an integer Taylor series in Q30,
   // rounded half up to the sample scale and held below +1.0.
   function automatic rom_type build_rom();
      rom_type rom;
      longint  x;
      longint  x2;
      longint  term;
      longint  sum;
      longint  v;
      for (int k = 0; k <= DEPTH; k++) begin
         x    = const_quotient(PI2_Q30 * longint'(k), longint'(DEPTH));
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int n = 1; n <= 8; n++) begin
            term = const_quotient((term * x2) >> 30, longint'(4 * n * n + 2 * n));
            if (n[0]) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = (sum * SCALE + (longint'(1) << 29)) >> 30;
         if (v > SMAX) begin
            v = SMAX;
         end
         rom[k] = v[SB-2:0];
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [SB-2:0] q_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff <= SINE_ROM[addr];
      end
   end

   assign rd_data = q_ff;

endmodule

/* rtl/phase_accumulator_waveform_osc.sv */
// Top level of the phase accumulator oscillator with four waveforms.
// Depends on pawo_pkg, pawo_ifs, pawo_phase_store and pawo_sine_rom.
//
// Numerically controlled oscillator. Each input item carries a signed frequency
// in units of 1/256 Hz; the block multiplies it by the tick period register
// (units of 2^-40 s), keeps bits 47 to 16 of the product as the phase step and
// adds it to a 32-bit phase that wraps modulo one cycle. Every item yields one
// result item: the updated phase and one sample of the selected waveform
// (sine, square, saw or triangle; other codes give zero) in signed Q1.15 form,
// SAMPLE_BITS wide, with +1.0 held at the largest positive code. The block
// takes one item per cycle while the output is not stalled. The pipeline has
// five stages: the step multiplier, the read-modify-write of the phase memory
// (a one-entry memory with a registered read, whose write data is forwarded
// to the next item), the table address computation, the sine table read, and
// the waveform select into the output register. Each stage holds its item
// on its own, so a stalled result does not stop items from moving into empty
// stages behind it. After reset the phase reads as zero at once; no clearing
// pass is needed. The two registers are written through the register port,
// which is always ready; they are to be written only while no item is in
// flight.
module phase_accumulator_waveform_osc #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int SAMPLE_BITS      = 16
) (
   input logic         clock,
   input logic         reset,
   pawo_req_if.sink    req_chan,
   pawo_rsp_if.source  rsp_chan,
   pawo_csr_if.sink    csr_chan
);
   import pawo_pkg::*;

   localparam int AW   = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int IPW  = 30 + AW;
   localparam int SB   = SAMPLE_BITS;
   localparam int TRW  = SB + 2;

   // Configuration registers.
   logic [WAVE_W-1:0] wave_ff;
   logic [TICK_W-1:0] tick_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= WAVE_SINE;
         tick_ff <= TICK_PERIOD_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_WAVE_SELECT: begin
               wave_ff <= csr_chan.data[WAVE_W-1:0];
            end
            CSR_TICK_PERIOD: begin
               tick_ff <= csr_chan.data[TICK_W-1:0];
            end
            default: begin
               // Writes to undefined indexes are dropped.
            end
         endcase
      end
   end

   // Stage valid bits and the ready chain. A stage may load when it is
   // empty or when the stage after it is loading.
   logic s1_vld_ff;
   logic s2_vld_ff;
   logic s3_vld_ff;
   logic s4_vld_ff;
   logic s5_vld_ff;
   logic s1_rdy;
   logic s2_rdy;
   logic s3_rdy;
   logic s4_rdy;
   logic s5_rdy;

   always_comb begin
      s5_rdy = !s5_vld_ff || rsp_chan.ready;
      s4_rdy = !s4_vld_ff || s5_rdy;
      s3_rdy = !s3_vld_ff || s4_rdy;
      s2_rdy = !s2_vld_ff || s3_rdy;
      s1_rdy = !s1_vld_ff || s2_rdy;
   end

   assign req_chan.ready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_vld_ff <= req_chan.valid;
         end
         if (s2_rdy) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_rdy) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (s4_rdy) begin
            s4_vld_ff <= s3_vld_ff;
         end
         if (s5_rdy) begin
            s5_vld_ff <= s4_vld_ff;
         end
      end
   end

   // Stage 1: the phase step. The signed frequency times the unsigned tick
   // period is in units of 2^-48 of a waveform period; bits 47 to 16 are the
   // step, the floor of the product over 2^16, kept modulo one whole period.
   logic signed [PROD_W-1:0] step_prod;
   logic [PHASE_W-1:0]       step_in;
   logic [PHASE_W-1:0]       step_ff;

   always_comb begin
      step_prod = PROD_W'(req_chan.frequency) * $signed({1'b0, tick_ff});
      step_in   = step_prod[STEP_LSB +: PHASE_W];
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && req_chan.valid) begin
         step_ff <= step_in;
      end
   end

   // Stage 2: read-modify-write of the phase. The store forwards the last
   // write, so back-to-back items chain through the adder without a bubble.
   logic               ph_wr_en;
   logic [PHASE_W-1:0] ph_cur;
   logic [PHASE_W-1:0] ph2_in;
   logic [PHASE_W-1:0] ph2_ff;

   assign ph_wr_en = s2_rdy && s1_vld_ff;
   assign ph2_in   = ph_cur + step_ff;

   pawo_phase_store u_phase_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ph_wr_en),
      .wr_data (ph2_in),
      .rd_data (ph_cur)
   );

   always_ff @(posedge clock) begin
      if (ph_wr_en) begin
         ph2_ff <= ph2_in;
      end
   end

   // Stage 3: table address. The index is the fraction of the quarter cycle
   // times the table depth; odd quadrants run the table backwards.
   logic [IPW-1:0]     idx_prod;
   logic [AW-1:0]      idx;
   logic [AW-1:0]      addr_in;
   logic [AW-1:0]      addr_ff;
   logic [PHASE_W-1:0] ph3_ff;

   always_comb begin
      idx_prod = IPW'(ph2_ff[29:0]) * IPW'(SINE_TABLE_DEPTH);
      idx      = idx_prod[30 +: AW];
      if (ph2_ff[30]) begin
         addr_in = AW'(SINE_TABLE_DEPTH) - idx;
      end else begin
         addr_in = idx;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_rdy && s2_vld_ff) begin
         addr_ff <= addr_in;
         ph3_ff  <= ph2_ff;
      end
   end

   // Stage 4: sine table read, registered in the table.
   logic               rom_rd_en;
   logic [SB-2:0]      rom_q;
   logic [PHASE_W-1:0] ph4_ff;

   assign rom_rd_en = s4_rdy && s3_vld_ff;

   pawo_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH),
      .SB    (SB),
      .AW    (AW)
   ) u_sine_rom (
      .clock   (clock),
      .rd_en   (rom_rd_en),
      .addr    (addr_ff),
      .rd_data (rom_q)
   );

   always_ff @(posedge clock) begin
      if (rom_rd_en) begin
         ph4_ff <= ph3_ff;
      end
   end

   // Stage 5: waveform select into the output register.
   logic [PHASE_W-1:0]    tri_dist;
   logic [SB:0]           tri_scaled;
   logic signed [TRW-1:0] tri_val;
   logic [SB-1:0]         sample_in;
   logic [SB-1:0]         sample_ff;
   logic [PHASE_W-1:0]    phase_ff;

   always_comb begin
      if (ph4_ff[PHASE_W-1]) begin
         tri_dist = ph4_ff - HALF_CYCLE;
      end else begin
         tri_dist = HALF_CYCLE - ph4_ff;
      end
      tri_scaled = tri_dist[PHASE_W-1 -: SB + 1];
      tri_val    = $signed(TRW'(1) << (SB - 1)) - $signed({1'b0, tri_scaled});

      case (wave_ff)
         WAVE_SINE: begin
            if (ph4_ff[PHASE_W-1]) begin
               sample_in = SB'(0) - {1'b0, rom_q};
            end else begin
               sample_in = {1'b0, rom_q};
            end
         end
         WAVE_SQUARE: begin
            // Below half a cycle the largest positive code, then -1.0.
            sample_in = {ph4_ff[PHASE_W-1], {(SB - 1){!ph4_ff[PHASE_W-1]}}};
         end
         WAVE_SAW: begin
            sample_in = {!ph4_ff[PHASE_W-1], ph4_ff[PHASE_W-2 -: SB - 1]};
         end
         WAVE_TRIANGLE: begin
            // Only the peak reaches +1.0, which is held at the largest code.
            if (tri_val > $signed((TRW'(1) << (SB - 1)) - TRW'(1))) begin
               sample_in = {1'b0, {(SB - 1){1'b1}}};
            end else begin
               sample_in = tri_val[SB-1:0];
            end
         end
         default: begin
            sample_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s5_rdy && s4_vld_ff) begin
         sample_ff <= sample_in;
         phase_ff  <= ph4_ff;
      end
   end

   assign rsp_chan.valid     = s5_vld_ff;
   assign rsp_chan.sample    = $signed(sample_ff);
   assign rsp_chan.phase_now = phase_ff;

endmodule

/* rtl/pawo_checker.sv */
// Port checker of the phase accumulator oscillator and its bind statement.
// Depends on pawo_pkg, pawo_ifs and assert_macros.svh.
`include "assert_macros.svh"

module pawo_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   pawo_req_if.sink    req_chan,
   pawo_rsp_if.source  rsp_chan,
   pawo_csr_if.sink    csr_chan
);
   import pawo_pkg::*;

   // Waveform code as last written through the register port.
   logic [WAVE_W-1:0] wave_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= WAVE_SINE;
      end else if (csr_chan.valid && csr_chan.ready &&
                   csr_chan.index == CSR_WAVE_SELECT) begin
         wave_ff <= csr_chan.data[WAVE_W-1:0];
      end
   end

   `ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid, "result item withdrawn while stalled")
   `ASSERT_NEXT(a_rsp_phase_holds, clock, reset, rsp_chan.valid && !rsp_chan.ready, $stable(rsp_chan.phase_now), "stalled phase changed")
   `ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !rsp_chan.valid, req_chan.ready, "input refused with an empty output stage")
   `ASSERT_IMPLIES(a_saw_matches_phase, clock, reset, rsp_chan.valid && wave_ff == WAVE_SAW, rsp_chan.sample == $signed({!rsp_chan.phase_now[31], rsp_chan.phase_now[30 -: SAMPLE_BITS - 1]}), "saw sample disagrees with phase")

endmodule

bind phase_accumulator_waveform_osc pawo_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_pawo_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan),
   .csr_chan (csr_chan)
);
